[src/eau_pkg.sv]
`timescale 1ns / 1ps

package eau_pkg;

  // item kinds
  localparam logic [1:0] KIND_EA    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // operand classes
  localparam logic [1:0] CLS_DREG = 2'd0;
  localparam logic [1:0] CLS_AREG = 2'd1;
  localparam logic [1:0] CLS_MEM  = 2'd2;
  localparam logic [1:0] CLS_IMM  = 2'd3;

  // operand sizes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  // addressing modes
  localparam logic [2:0] MODE_DREG    = 3'd0;
  localparam logic [2:0] MODE_AREG    = 3'd1;
  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  // sub-modes of mode 7
  localparam logic [2:0] SUB_ABS_W  = 3'd0;
  localparam logic [2:0] SUB_ABS_L  = 3'd1;
  localparam logic [2:0] SUB_PC_DSP = 3'd2;
  localparam logic [2:0] SUB_PC_IDX = 3'd3;
  localparam logic [2:0] SUB_IMM    = 3'd4;

  localparam logic [31:0] MASK_RESET = 32'h00ff_ffff;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [1:0]  size;
    logic        is_destination;
    logic [31:0] pc;
    logic [15:0] ext_first;
    logic [15:0] ext_second;
    logic [31:0] write_value;
    logic        address_file;
  } item_t;

  typedef struct packed {
    logic [1:0]  ea_class;
    logic [31:0] ea_value;
    logic [4:0]  cycles;
    logic [1:0]  words_used;
    logic        is_memory;
    logic        is_writable;
    logic        invalid_mode;
    logic [31:0] read_value;
  } res_t;

  // register file write request, address bit 3 selects the address file
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } wr_t;

  // register file read request, two ports
  typedef struct packed {
    logic       en;
    logic [3:0] addr_a;
    logic [3:0] addr_b;
  } rd_req_t;

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // address calculation cost; row is the mode, or 8 plus the sub-mode
  function automatic logic [4:0] cost_lookup(input logic [3:0] row, input logic lng);
    logic [4:0] c;
    begin
      case (row)
        4'd2, 4'd3, 4'd12: c = lng ? 5'd8  : 5'd4;
        4'd4:              c = lng ? 5'd10 : 5'd6;
        4'd5, 4'd8, 4'd10: c = lng ? 5'd12 : 5'd8;
        4'd6, 4'd11:       c = lng ? 5'd14 : 5'd10;
        4'd9:              c = lng ? 5'd16 : 5'd12;
        default:           c = 5'd0;
      endcase
      return c;
    end
  endfunction

endpackage

[src/eau_regfile.sv]
`timescale 1ns / 1ps

module eau_regfile (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  eau_pkg::wr_t    wr_i,
  input  eau_pkg::rd_req_t rd_i,
  output logic [31:0]     rd_a_o,
  output logic [31:0]     rd_b_o
);
  import eau_pkg::*;

  // entries 0..7 data registers, 8..15 address registers
  logic [31:0] mem_q [16];
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mem_q[i] <= '0;
      end
      rd_a_q <= '0;
      rd_b_q <= '0;
    end else begin
      if (wr_i.en) begin
        mem_q[wr_i.addr] <= wr_i.data;
      end
      // write-first: a read in the same cycle as a write sees the new value
      if (rd_i.en) begin
        rd_a_q <= (wr_i.en && wr_i.addr == rd_i.addr_a) ? wr_i.data : mem_q[rd_i.addr_a];
        rd_b_q <= (wr_i.en && wr_i.addr == rd_i.addr_b) ? wr_i.data : mem_q[rd_i.addr_b];
      end
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

[src/eau_calc.sv]
`timescale 1ns / 1ps

module eau_calc (
  input  eau_pkg::item_t item_i,
  input  logic [31:0]    rd_a_i,
  input  logic [31:0]    rd_b_i,
  input  logic [31:0]    address_mask_i,
  output eau_pkg::res_t  res_o,
  output eau_pkg::wr_t   wr_o
);
  import eau_pkg::*;

  logic [1:0]  sz;
  logic        lng;
  logic [31:0] smask;
  logic [31:0] step;
  logic [31:0] ext_val;
  logic [31:0] idx;
  logic [31:0] idx_base;
  logic [31:0] indexed_addr;
  logic [31:0] long_imm;
  logic [31:0] postinc_an;
  logic [31:0] predec_an;
  logic [3:0]  row;
  logic [31:0] wmasked;

  always_comb begin
    sz  = (item_i.size == 2'd3) ? SIZE_LONG : item_i.size;
    lng = (sz == SIZE_LONG);
    case (sz)
      SIZE_BYTE: smask = 32'h0000_00ff;
      SIZE_WORD: smask = 32'h0000_ffff;
      default:   smask = 32'hffff_ffff;
    endcase
    // a7 keeps the stack word aligned on byte steps
    case (sz)
      SIZE_BYTE: step = (item_i.reg_req == 3'd7) ? 32'd2 : 32'd1;
      SIZE_WORD: step = 32'd2;
      default:   step = 32'd4;
    endcase
    wmasked = item_i.write_value & smask;
    case (sz)
      SIZE_BYTE: ext_val = sx8(wmasked[7:0]);
      SIZE_WORD: ext_val = sx16(wmasked[15:0]);
      default:   ext_val = wmasked;
    endcase

    idx          = item_i.ext_first[11] ? rd_b_i : sx16(rd_b_i[15:0]);
    idx_base     = (item_i.mode == MODE_EXT) ? item_i.pc : rd_a_i;
    indexed_addr = idx_base + idx + sx8(item_i.ext_first[7:0]);
    long_imm     = {item_i.ext_first, item_i.ext_second};
    postinc_an   = (rd_a_i + step) & address_mask_i;
    predec_an    = (rd_a_i - step) & address_mask_i;
    row          = (item_i.mode == MODE_EXT) ? {1'b1, item_i.reg_req} : {1'b0, item_i.mode};

    res_o = '0;
    wr_o  = '0;

    case (item_i.kind)
      KIND_WRITE: begin
        res_o.ea_class = item_i.address_file ? CLS_AREG : CLS_DREG;
        wr_o.en        = 1'b1;
        wr_o.addr      = {item_i.address_file, item_i.reg_req};
        wr_o.data      = item_i.address_file ? ext_val : ((rd_a_i & ~smask) | wmasked);
      end
      KIND_READ: begin
        res_o.ea_class   = item_i.address_file ? CLS_AREG : CLS_DREG;
        res_o.read_value = rd_a_i & smask;
      end
      KIND_EA: begin
        if (item_i.mode == MODE_EXT && item_i.reg_req > SUB_IMM) begin
          res_o.invalid_mode = 1'b1;
        end else begin
          res_o.cycles      = cost_lookup(row, lng);
          res_o.ea_class    = CLS_MEM;
          res_o.is_memory   = 1'b1;
          res_o.is_writable = 1'b1;
          case (item_i.mode)
            MODE_DREG: begin
              res_o.ea_class  = CLS_DREG;
              res_o.is_memory = 1'b0;
            end
            MODE_AREG: begin
              res_o.ea_class  = CLS_AREG;
              res_o.is_memory = 1'b0;
            end
            MODE_IND: begin
              res_o.ea_value = rd_a_i;
            end
            MODE_POSTINC: begin
              res_o.ea_value = rd_a_i;
              wr_o.en        = 1'b1;
              wr_o.addr      = {1'b1, item_i.reg_req};
              wr_o.data      = postinc_an;
            end
            MODE_PREDEC: begin
              res_o.ea_value = predec_an;
              if (item_i.is_destination) begin
                res_o.cycles = lng ? 5'd8 : 5'd4;
              end
              wr_o.en   = 1'b1;
              wr_o.addr = {1'b1, item_i.reg_req};
              wr_o.data = predec_an;
            end
            MODE_DISP: begin
              res_o.ea_value   = rd_a_i + sx16(item_i.ext_first);
              res_o.words_used = 2'd1;
            end
            MODE_INDEX: begin
              res_o.ea_value   = indexed_addr;
              res_o.words_used = 2'd1;
            end
            default: begin
              case (item_i.reg_req)
                SUB_ABS_W: begin
                  res_o.ea_value   = sx16(item_i.ext_first);
                  res_o.words_used = 2'd1;
                end
                SUB_ABS_L: begin
                  res_o.ea_value   = long_imm;
                  res_o.words_used = 2'd2;
                end
                SUB_PC_DSP: begin
                  res_o.ea_value    = item_i.pc + sx16(item_i.ext_first);
                  res_o.words_used  = 2'd1;
                  res_o.is_writable = 1'b0;
                end
                SUB_PC_IDX: begin
                  res_o.ea_value    = indexed_addr;
                  res_o.words_used  = 2'd1;
                  res_o.is_writable = 1'b0;
                end
                default: begin
                  res_o.ea_class    = CLS_IMM;
                  res_o.is_memory   = 1'b0;
                  res_o.is_writable = 1'b0;
                  if (lng) begin
                    res_o.ea_value   = long_imm;
                    res_o.words_used = 2'd2;
                  end else begin
                    res_o.ea_value   = {16'h0000, item_i.ext_first} & smask;
                    res_o.words_used = 2'd1;
                  end
                end
              endcase
            end
          endcase
        end
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

[src/m68k_effective_address_unit.sv]
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o     kind .. address_file, one item per operand
// out       output     out_valid_o / out_ready_i   ea_class .. read_value, one item per input
// cfg       input      cfg_valid_i / cfg_ready_o   cfg_data_i, address mask
//
// one item per cycle sustained while the output is not stalled
// stage one holds the item and the registered register file reads, stage two the result
// register file updates ((An)+, -(An), register writes) land as an item leaves stage one,
// so the next item's reads see them through the write-first read port
// async active-low reset clears all sixteen registers and sets the mask to 0x00ffffff
// a stalled output holds stage two; an empty stage one still takes an item meanwhile

module m68k_effective_address_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  reg_req_i,
  input  logic [1:0]  size_i,
  input  logic        is_destination_i,
  input  logic [31:0] pc_i,
  input  logic [15:0] ext_first_i,
  input  logic [15:0] ext_second_i,
  input  logic [31:0] write_value_i,
  input  logic        address_file_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  ea_class_o,
  output logic [31:0] ea_value_o,
  output logic [4:0]  cycles_o,
  output logic [1:0]  words_used_o,
  output logic        is_memory_o,
  output logic        is_writable_o,
  output logic        invalid_mode_o,
  output logic [31:0] read_value_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import eau_pkg::*;

  // stage one: item register
  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    s1_advance;
  logic    in_accept;

  // stage two: result register
  logic    out_valid_q;
  res_t    res_q;
  res_t    res_d;

  logic [31:0] address_mask_q;

  wr_t         calc_wr;
  wr_t         rf_wr;
  rd_req_t     rf_rd;
  logic [31:0] rd_a;
  logic [31:0] rd_b;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_mask_q <= MASK_RESET;
    end else if (cfg_valid_i) begin
      address_mask_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.kind           <= kind_i;
      s1_item_q.mode           <= mode_i;
      s1_item_q.reg_req        <= reg_req_i;
      s1_item_q.size           <= size_i;
      s1_item_q.is_destination <= is_destination_i;
      s1_item_q.pc             <= pc_i;
      s1_item_q.ext_first      <= ext_first_i;
      s1_item_q.ext_second     <= ext_second_i;
      s1_item_q.write_value    <= write_value_i;
      s1_item_q.address_file   <= address_file_i;
    end
  end

  // port a: the operand register (An for address modes), port b: the index register
  always_comb begin
    rf_rd.en     = in_accept;
    rf_rd.addr_a = (kind_i == KIND_EA) ? {1'b1, reg_req_i} : {address_file_i, reg_req_i};
    rf_rd.addr_b = {ext_first_i[15], ext_first_i[14:12]};
  end

  always_comb begin
    rf_wr    = calc_wr;
    rf_wr.en = calc_wr.en && s1_advance;
  end

  eau_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (rf_wr),
    .rd_i   (rf_rd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  eau_calc u_calc (
    .item_i         (s1_item_q),
    .rd_a_i         (rd_a),
    .rd_b_i         (rd_b),
    .address_mask_i (address_mask_q),
    .res_o          (res_d),
    .wr_o           (calc_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ea_class_o     = res_q.ea_class;
  assign ea_value_o     = res_q.ea_value;
  assign cycles_o       = res_q.cycles;
  assign words_used_o   = res_q.words_used;
  assign is_memory_o    = res_q.is_memory;
  assign is_writable_o  = res_q.is_writable;
  assign invalid_mode_o = res_q.invalid_mode;
  assign read_value_o   = res_q.read_value;

`ifndef SYNTH
  // an empty result register never holds back the input
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  // memory class and memory flag agree on every result
  a_mem_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ea_class_o == CLS_MEM) == is_memory_o))
    else $error("memory flag disagrees with operand class");

  // an invalid sub-mode carries nothing else
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_mode_o) |->
      (ea_value_o == 32'd0 && cycles_o == 5'd0 && words_used_o == 2'd0 && !is_writable_o))
    else $error("invalid mode result has nonzero fields");

  // register file is only written as an item leaves stage one
  a_write_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> (s1_valid_q && (!out_valid_q || out_ready_i)))
    else $error("register file written without an item advancing");
`endif

endmodule
